[rtl/rkb_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the
// receptor RK4 binding step block. No dependencies.
package rkb_pkg;

  typedef logic signed [47:0] q_t;
  typedef q_t [4:0] vec5_t;

  localparam q_t VMAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t VMIN = 48'sh8000_0000_0000;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TIME_STEP        = 2'd0;
  localparam reg_idx_t REG_VOXEL_VOLUME     = 2'd1;
  localparam reg_idx_t REG_INV_VOXEL_VOLUME = 2'd2;

  localparam logic [46:0] RST_TIME_STEP        = 47'd167772;
  localparam logic [46:0] RST_VOXEL_VOLUME     = 47'd134217728000;
  localparam logic [46:0] RST_INV_VOXEL_VOLUME = 47'd2097;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [46:0] dt;
    logic [46:0] vv;
    logic [46:0] ivv;
  } cfg_t;

  // word as it arrives on the input channel
  typedef struct packed {
    vec5_t       x;
    logic [46:0] kb;
    logic [46:0] ke;
    logic [46:0] kl;
    logic [46:0] kr;
    q_t          dens;
    logic [23:0] rfrac;
    logic        elig;
  } raw_t;

  // word after the front end: random value aligned to the fraction point
  typedef struct packed {
    vec5_t       x;
    logic [46:0] kb;
    logic [46:0] ke;
    logic [46:0] kl;
    logic [46:0] kr;
    q_t          dens;
    q_t          r;
    logic        elig;
  } item_t;

  typedef struct packed {
    vec5_t x;
    q_t    dens;
  } res_t;

  // per-stage record of the back-end pipeline
  typedef struct packed {
    vec5_t       ox;
    vec5_t       x;
    q_t          odens;
    q_t          dens;
    q_t          r;
    logic        elig;
    logic [46:0] kb;
    logic [46:0] ke;
    logic [46:0] kl;
    logic [46:0] kr;
    q_t          nvir;
    q_t          p;
    q_t          alpha;
    q_t          whole;
    q_t          frac;
    logic        bge;
    vec5_t [2:0] fk;
    vec5_t       acc;
    vec5_t       d3;
    vec5_t       d4;
  } rec_t;

  function automatic q_t sat_add(q_t a, q_t b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) return s[48] ? VMIN : VMAX;
    return s[47:0];
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [48:0] s;
    s = 49'(a) - 49'(b);
    if (s[48] != s[47]) return s[48] ? VMIN : VMAX;
    return s[47:0];
  endfunction

  function automatic q_t sat_neg(q_t a);
    if (a == VMIN) return VMAX;
    return -a;
  endfunction

  // right-hand side of the endocytosis / release / recycling system
  function automatic vec5_t deriv_f(q_t rec, q_t endo, q_t rel);
    vec5_t f;
    f[0] = rec;
    f[1] = sat_neg(endo);
    f[2] = sat_sub(endo, rel);
    f[3] = sat_sub(rel, rec);
    f[4] = rel;
    return f;
  endfunction

endpackage

[rtl/rkb_mul.sv]
// Five-stage signed fixed-point multiplier: floor(a*b / 2^FRAC_BITS), saturated.
// 48x48 product built from four 24x24 partial products. Uses rkb_pkg.
module rkb_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  rkb_pkg::q_t a,
  input  rkb_pkg::q_t b,
  output rkb_pkg::q_t y
);

  rkb_pkg::q_t a1_r, b1_r;
  logic        neg2_r, neg3_r, neg4_r;
  logic [47:0] ma2_r, mb2_r;
  logic [47:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [95:0] sum4_r;
  rkb_pkg::q_t y_r;

  logic [47:0] ma_nxt, mb_nxt;
  logic [95:0] sum_nxt;
  logic [95:0] q, qr;
  logic        rem;
  rkb_pkg::q_t y_nxt;

  assign ma_nxt  = a1_r[47] ? 48'(-a1_r) : 48'(a1_r);
  assign mb_nxt  = b1_r[47] ? 48'(-b1_r) : 48'(b1_r);
  assign sum_nxt = 96'(pp00_r) + ((96'(pp01_r) + 96'(pp10_r)) << 24) + (96'(pp11_r) << 48);

  always_comb begin
    q   = sum4_r >> FRAC_BITS;
    rem = |(sum4_r & ((96'(1) << FRAC_BITS) - 96'(1)));
    qr  = q + 96'(neg4_r && rem);
    if (!neg4_r) begin
      y_nxt = (qr > 96'(rkb_pkg::VMAX)) ? rkb_pkg::VMAX : rkb_pkg::q_t'(qr[47:0]);
    end else begin
      y_nxt = (qr > (96'(1) << 47)) ? rkb_pkg::VMIN : -rkb_pkg::q_t'(qr[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a;
      b1_r   <= b;
      neg2_r <= a1_r[47] ^ b1_r[47];
      ma2_r  <= ma_nxt;
      mb2_r  <= mb_nxt;
      neg3_r <= neg2_r;
      pp00_r <= ma2_r[23:0]  * mb2_r[23:0];
      pp01_r <= ma2_r[23:0]  * mb2_r[47:24];
      pp10_r <= ma2_r[47:24] * mb2_r[23:0];
      pp11_r <= ma2_r[47:24] * mb2_r[47:24];
      neg4_r <= neg3_r;
      sum4_r <= sum_nxt;
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[rtl/rkb_div3.sv]
// Five-stage floor division of a signed 48-bit value by three.
// Offset to unsigned, reciprocal multiply, one correction step. Uses rkb_pkg.
module rkb_div3 (
  input  logic        clk,
  input  logic        en,
  input  rkb_pkg::q_t a,
  output rkb_pkg::q_t y
);

  // floor(2^50 / 3); offset 3 * 2^47 keeps the dividend positive
  localparam logic [48:0] M3  = 49'd375299968947541;
  localparam logic [48:0] OFF = 49'd422212465065984;

  logic [48:0] u1_r, u2_r, u3_r;
  logic [49:0] pp00_r;
  logic [48:0] pp01_r, pp10_r;
  logic [47:0] pp11_r;
  logic [97:0] sum3_r;
  logic [47:0] q4_r;
  logic [2:0]  rem4_r;
  rkb_pkg::q_t y_r;

  logic [97:0] sum_nxt;
  logic [47:0] q0;
  logic [2:0]  rem_nxt;
  logic [48:0] t;

  assign sum_nxt = 98'(pp00_r) + ((98'(pp01_r) + 98'(pp10_r)) << 25) + (98'(pp11_r) << 50);
  assign q0      = sum3_r[97:50];
  // true remainder lies in [0,6), so three bits are enough
  assign rem_nxt = u3_r[2:0] - (q0[2:0] + {q0[1:0], 1'b0});
  assign t       = 49'(q4_r) + 49'(rem4_r >= 3'd3) - (49'(1) << 47);

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= 49'(a) + OFF;
      u2_r   <= u1_r;
      pp00_r <= u1_r[24:0]  * M3[24:0];
      pp01_r <= u1_r[24:0]  * M3[48:25];
      pp10_r <= u1_r[48:25] * M3[24:0];
      pp11_r <= u1_r[48:25] * M3[48:25];
      u3_r   <= u2_r;
      sum3_r <= sum_nxt;
      q4_r   <= q0;
      rem4_r <= rem_nxt;
      y_r    <= t[47:0];
    end
  end

  assign y = y_r;

endmodule

[rtl/rkb_front.sv]
// Front end: input register, random fraction alignment, push into the queue.
// Uses rkb_pkg.
module rkb_front #(
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rkb_pkg::raw_t  in_word,
  output logic           push_valid,
  input  logic           push_ready,
  output rkb_pkg::item_t push_word
);

  localparam int LSH = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int RSH = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;

  rkb_pkg::item_t hold_r, item_nxt;
  logic           hold_v_r;

  always_comb begin
    item_nxt.x    = in_word.x;
    item_nxt.kb   = in_word.kb;
    item_nxt.ke   = in_word.ke;
    item_nxt.kl   = in_word.kl;
    item_nxt.kr   = in_word.kr;
    item_nxt.dens = in_word.dens;
    item_nxt.r    = (rkb_pkg::q_t'(in_word.rfrac) << LSH) >> RSH;
    item_nxt.elig = in_word.elig;
  end

  assign in_ready = !hold_v_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_ready) begin
      hold_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= item_nxt;
    end
  end

  assign push_valid = hold_v_r;
  assign push_word  = hold_r;

endmodule

[rtl/rkb_queue.sv]
// Four-word queue between front end and back end. Uses rkb_pkg.
module rkb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rkb_pkg::item_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rkb_pkg::item_t pop_word
);

  rkb_pkg::item_t                mem_r [rkb_pkg::QDEPTH];
  logic [rkb_pkg::QAW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [rkb_pkg::QAW:0]         cnt_r;
  logic                          do_push, do_pop;

  assign push_ready = cnt_r != (rkb_pkg::QAW + 1)'(rkb_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_word   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[rtl/rkb_back.sv]
// Back end: RK4 step and binding update as one stalling pipeline.
// Uses rkb_pkg, rkb_mul and rkb_div3.
module rkb_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rkb_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rkb_pkg::item_t pop_word,
  output logic           out_valid,
  input  logic           out_ready,
  output rkb_pkg::res_t  out_res
);

  localparam int LM   = 5;             // rkb_mul latency
  localparam int LD   = 5;             // rkb_div3 latency
  localparam int KA   = 7 * LM + LD;   // quotients ready
  localparam int KB   = KA + 2;        // dt * weighted sum issued
  localparam int KE   = KB + LM;       // RK4 result
  localparam int KW   = KE + 2;        // whole * inverse volume issued
  localparam int KG   = KW + LM;       // density lowered
  localparam int LAST = KG + 2;
  localparam int NST  = LAST + 1;

  localparam rkb_pkg::q_t ONE   = rkb_pkg::q_t'(1) << FRAC_BITS;
  localparam rkb_pkg::q_t FMASK = ONE - rkb_pkg::q_t'(1);

  rkb_pkg::rec_t st_r   [NST];
  rkb_pkg::rec_t st_nxt [NST];
  logic [NST-1:0] v_r;
  logic           en;

  rkb_pkg::q_t dm_a [4][3], dm_b [4][3], dm_y [4][3];
  rkb_pkg::q_t hm_a [3][5], hm_b [3][5], hm_y [3][5];
  rkb_pkg::q_t pm_a [3], pm_b [3], pm_y [3];
  rkb_pkg::q_t fm_a [5], fm_y [5];
  rkb_pkg::q_t dv_a [5][4], dv_y [5][4];
  rkb_pkg::q_t vm_y, wm_a, wm_y;
  rkb_pkg::q_t dt_q, half_q, vv_q, ivv_q;

  assign dt_q   = {1'b0, cfg.dt};
  assign half_q = {2'b0, cfg.dt[46:1]};
  assign vv_q   = {1'b0, cfg.vv};
  assign ivv_q  = {1'b0, cfg.ivv};

  assign en        = !v_r[LAST] || out_ready;
  assign pop_ready = en;
  assign out_valid = v_r[LAST];
  assign out_res.x    = st_r[LAST].x;
  assign out_res.dens = st_r[LAST].dens;

  always_comb begin
    rkb_pkg::vec5_t f;
    rkb_pkg::vec5_t xs;
    rkb_pkg::rec_t  c;
    rkb_pkg::q_t    wh;
    logic           att;

    st_nxt[0]       = '0;
    st_nxt[0].ox    = pop_word.x;
    st_nxt[0].x     = pop_word.x;
    st_nxt[0].odens = pop_word.dens;
    st_nxt[0].dens  = pop_word.dens;
    st_nxt[0].r     = pop_word.r;
    st_nxt[0].elig  = pop_word.elig;
    st_nxt[0].kb    = pop_word.kb;
    st_nxt[0].ke    = pop_word.ke;
    st_nxt[0].kl    = pop_word.kl;
    st_nxt[0].kr    = pop_word.kr;

    for (int k = 1; k < NST; k++) st_nxt[k] = st_r[k-1];

    // first derivative on the item's own amounts
    dm_a[0][0] = {1'b0, st_r[0].kr};  dm_b[0][0] = st_r[0].ox[3];
    dm_a[0][1] = {1'b0, st_r[0].ke};  dm_b[0][1] = st_r[0].ox[1];
    dm_a[0][2] = {1'b0, st_r[0].kl};  dm_b[0][2] = st_r[0].ox[2];

    // derivatives at the intermediate points
    for (int g = 1; g < 4; g++) begin
      for (int i = 0; i < 5; i++) xs[i] = rkb_pkg::sat_add(st_r[2*g*LM].ox[i], hm_y[g-1][i]);
      dm_a[g][0] = {1'b0, st_r[2*g*LM].kr};  dm_b[g][0] = xs[3];
      dm_a[g][1] = {1'b0, st_r[2*g*LM].ke};  dm_b[g][1] = xs[1];
      dm_a[g][2] = {1'b0, st_r[2*g*LM].kl};  dm_b[g][2] = xs[2];
    end

    // slopes k1..k3, then step toward the next point
    for (int g = 0; g < 3; g++) begin
      f = rkb_pkg::deriv_f(dm_y[g][0], dm_y[g][1], dm_y[g][2]);
      st_nxt[(2*g+1)*LM+1].fk[g] = f;
      for (int i = 0; i < 5; i++) begin
        hm_a[g][i] = f[i];
        hm_b[g][i] = (g == 2) ? dt_q : half_q;
      end
    end

    // binding probability chain and virion count
    pm_a[0] = dt_q;     pm_b[0] = {1'b0, st_r[0].kb};
    pm_a[1] = pm_y[0];  pm_b[1] = st_r[LM].dens;
    pm_a[2] = pm_y[1];  pm_b[2] = st_r[2*LM].ox[0];
    st_nxt[3*LM+1].p    = pm_y[2];
    st_nxt[LM+1].nvir   = vm_y;

    c = st_r[4*LM];
    st_nxt[4*LM+1].bge   = c.p >= ONE;
    st_nxt[4*LM+1].alpha = (c.p > c.nvir) ? c.nvir : c.p;

    // k4, then the /6 /3 /3 /6 weights (x/6 taken as floor(floor(x/2)/3))
    f = rkb_pkg::deriv_f(dm_y[3][0], dm_y[3][1], dm_y[3][2]);
    for (int i = 0; i < 5; i++) begin
      dv_a[i][0] = $signed(st_r[7*LM].fk[0][i]) >>> 1;
      dv_a[i][1] = st_r[7*LM].fk[1][i];
      dv_a[i][2] = st_r[7*LM].fk[2][i];
      dv_a[i][3] = $signed(f[i]) >>> 1;
    end

    for (int i = 0; i < 5; i++) begin
      st_nxt[KA+1].acc[i] = rkb_pkg::sat_add(dv_y[i][0], dv_y[i][1]);
      st_nxt[KA+1].d3[i]  = dv_y[i][2];
      st_nxt[KA+1].d4[i]  = dv_y[i][3];
      st_nxt[KA+2].acc[i] = rkb_pkg::sat_add(st_r[KA+1].acc[i], st_r[KA+1].d3[i]);
      fm_a[i]             = rkb_pkg::sat_add(st_r[KB].acc[i], st_r[KB].d4[i]);
      st_nxt[KE+1].x[i]   = rkb_pkg::sat_add(st_r[KE].ox[i], fm_y[i]);
    end

    // whole part of the deterministic bind, capped by free receptors
    c  = st_r[KE+1];
    wh = c.alpha & ~FMASK;
    if (wh > c.x[0]) wh = c.x[0];
    st_nxt[KE+2].whole = wh;
    st_nxt[KE+2].frac  = c.alpha & FMASK;

    c    = st_r[KW];
    wm_a = c.whole;
    if (c.bge) begin
      st_nxt[KW+1].x[0] = rkb_pkg::sat_sub(c.x[0], c.whole);
      st_nxt[KW+1].x[1] = rkb_pkg::sat_add(c.x[1], c.whole);
    end

    c = st_r[KG];
    if (c.bge) st_nxt[KG+1].dens = rkb_pkg::sat_sub(c.dens, wm_y);

    // single random attempt, then pass-through select for ineligible cells
    c   = st_r[KG+1];
    att = c.bge ? (c.r <= c.frac) : ((c.p > 0) && (c.r <= c.p));
    if (att && (c.x[0] >= ONE)) begin
      c.x[0] = rkb_pkg::sat_sub(c.x[0], ONE);
      c.x[1] = rkb_pkg::sat_add(c.x[1], ONE);
      c.dens = rkb_pkg::sat_sub(c.dens, ivv_q);
    end
    st_nxt[KG+2].x    = c.elig ? c.x : c.ox;
    st_nxt[KG+2].dens = c.elig ? c.dens : c.odens;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
  end

  for (genvar gg = 0; gg < 4; gg++) begin : g_dm
    for (genvar ii = 0; ii < 3; ii++) begin : g_m
      rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(dm_a[gg][ii]), .b(dm_b[gg][ii]), .y(dm_y[gg][ii])
      );
    end
  end

  for (genvar gg = 0; gg < 3; gg++) begin : g_hm
    for (genvar ii = 0; ii < 5; ii++) begin : g_m
      rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(hm_a[gg][ii]), .b(hm_b[gg][ii]), .y(hm_y[gg][ii])
      );
    end
  end

  for (genvar ii = 0; ii < 3; ii++) begin : g_pm
    rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(pm_a[ii]), .b(pm_b[ii]), .y(pm_y[ii])
    );
  end

  for (genvar ii = 0; ii < 5; ii++) begin : g_fm
    rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(fm_a[ii]), .b(dt_q), .y(fm_y[ii])
    );
    for (genvar jj = 0; jj < 4; jj++) begin : g_dv
      rkb_div3 u_div (
        .clk(clk), .en(en), .a(dv_a[ii][jj]), .y(dv_y[ii][jj])
      );
    end
  end

  rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_vm (
    .clk(clk), .en(en), .a(st_r[0].dens), .b(vv_q), .y(vm_y)
  );

  rkb_mul #(.FRAC_BITS(FRAC_BITS)) u_wm (
    .clk(clk), .en(en), .a(wm_a), .b(ivv_q), .y(wm_y)
  );

endmodule

[rtl/receptor_rk4_binding_step_top.sv]
// Receptor RK4 binding step: one word accepted and one result delivered per cycle
// while the output is taken. Path from input accept to out_valid: input register,
// four-word queue, 57-stage back end set by the chain of multipliers.
// Whole back end stalls together when the output word is not taken.
// Synchronous active-low reset clears valid state and loads register defaults.
// Uses rkb_pkg, rkb_front, rkb_queue, rkb_back.
module receptor_rk4_binding_step_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [47:0] in_unbound_external,
  input  logic signed [47:0] in_bound_external,
  input  logic signed [47:0] in_bound_internal,
  input  logic signed [47:0] in_unbound_internal,
  input  logic signed [47:0] in_internal_virion,
  input  logic [46:0]        in_binding_rate,
  input  logic [46:0]        in_endocytosis_rate,
  input  logic [46:0]        in_release_rate,
  input  logic [46:0]        in_recycling_rate,
  input  logic signed [47:0] in_external_density,
  input  logic [23:0]        in_random_fraction,
  input  logic               in_cell_eligible,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_new_unbound_external,
  output logic signed [47:0] out_new_bound_external,
  output logic signed [47:0] out_new_bound_internal,
  output logic signed [47:0] out_new_unbound_internal,
  output logic signed [47:0] out_new_internal_virion,
  output logic signed [47:0] out_new_external_density,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [46:0]        cfg_wdata
);

  rkb_pkg::cfg_t  cfg_r;
  rkb_pkg::raw_t  raw;
  rkb_pkg::item_t push_word, pop_word;
  rkb_pkg::res_t  res;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dt  <= rkb_pkg::RST_TIME_STEP;
      cfg_r.vv  <= rkb_pkg::RST_VOXEL_VOLUME;
      cfg_r.ivv <= rkb_pkg::RST_INV_VOXEL_VOLUME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rkb_pkg::REG_TIME_STEP:        cfg_r.dt  <= cfg_wdata;
        rkb_pkg::REG_VOXEL_VOLUME:     cfg_r.vv  <= cfg_wdata;
        rkb_pkg::REG_INV_VOXEL_VOLUME: cfg_r.ivv <= cfg_wdata;
        default:                       cfg_r     <= cfg_r;
      endcase
    end
  end

  assign raw.x[0]  = in_unbound_external;
  assign raw.x[1]  = in_bound_external;
  assign raw.x[2]  = in_bound_internal;
  assign raw.x[3]  = in_unbound_internal;
  assign raw.x[4]  = in_internal_virion;
  assign raw.kb    = in_binding_rate;
  assign raw.ke    = in_endocytosis_rate;
  assign raw.kl    = in_release_rate;
  assign raw.kr    = in_recycling_rate;
  assign raw.dens  = in_external_density;
  assign raw.rfrac = in_random_fraction;
  assign raw.elig  = in_cell_eligible;

  rkb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(raw),
    .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word)
  );

  rkb_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_word(push_word),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word)
  );

  rkb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_word(pop_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_new_unbound_external = res.x[0];
  assign out_new_bound_external   = res.x[1];
  assign out_new_bound_internal   = res.x[2];
  assign out_new_unbound_internal = res.x[3];
  assign out_new_internal_virion  = res.x[4];
  assign out_new_external_density = res.dens;

endmodule
